FILE: hdl/ultrasonic_echo_timer_unit_defines.svh
// Assertion macros used by the top-level file that checks this block.
`ifndef ULTRASONIC_ECHO_TIMER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_TIMER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define UET_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define UET_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/uet_pkg.sv
package uet_pkg;

  localparam int COUNT_BITS = 16;
  localparam int WIDE_W     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int ADDR_W     = 5;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WIDE_W-1:0]     wide_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TRIGGER = 2'd1,
    PH_WAIT    = 2'd2,
    PH_RECV    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_HOLDOFF   = 3'd1,
    REG_TRIG_W    = 3'd2,
    REG_RISE_MIN  = 3'd3,
    REG_RISE_MAX  = 3'd4,
    REG_WIDTH_MIN = 3'd5,
    REG_WIDTH_MAX = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  localparam int FLT_TIMEOUT = 0;
  localparam int FLT_BUSY    = 1;
  localparam int FLT_HOLDOFF = 2;
  localparam int FLT_RISE    = 3;
  localparam int FLT_WIDTH   = 4;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [15:0] holdoff_us;
    logic [7:0]  trigger_width_us;
    logic [15:0] rise_min_us;
    logic [15:0] rise_max_us;
    logic [15:0] width_min_us;
    logic [15:0] width_max_us;
  } cfg_t;

  // Declared from the highest bit down, so trigger_out sits at bit 0.
  typedef struct packed {
    logic [15:0] error_count;
    logic [4:0]  fault_flags;
    logic        new_value;
    logic [15:0] echo_width_us;
    logic        ready_res;
    logic        busy_res;
    logic        trigger_out;
  } res_t;

  localparam int RES_W  = $bits(res_t);
  localparam int DATA_W = ((RES_W + 7) / 8) * 8;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  function automatic wide_t wide_cnt(cnt_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t wide_reg(logic [15:0] v);
    return wide_t'(v);
  endfunction

endpackage

FILE: hdl/ultrasonic_echo_timer_unit.sv
// Channel   Direction  Contents
// s_axis    in         one word per microsecond tick: echo level, start request
// m_axis    out        one word per tick: trigger, status, stored width, faults, count
// apb       in         seven timing and window registers at byte addresses 0 to 24
//
// The tick's state update is one combinational pass from the state registers into the
// output register, so a word can be accepted every cycle while the output is not stalled.
// The input is accepted while the output register is empty or being emptied.
// Reset idles the phase, clears the run counters and the output register, marks the
// holdoff as elapsed, loads the stored width with 32767 and the registers with defaults.
// A stalled output holds its word and holds the input off until it is taken.
`include "ultrasonic_echo_timer_unit_defines.svh"

module ultrasonic_echo_timer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // echo_level, start_request
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // trigger_out, busy_res, ready_res, echo_width_us, new_value, fault_flags, error_count
  output logic [uet_pkg::DATA_W-1:0] m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uet_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import uet_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic valid_q;
  logic in_fire;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  uet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uet_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_fire),
    .echo_i  (s_axis_tdata[0]),
    .start_i (s_axis_tdata[1]),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      if (in_fire) begin
        valid_q <= 1'b1;
        res_q   <= res;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = DATA_W'(res_q);

  `UET_ASSERT_SAME(a_busy_not_ready, clk_i, rst_ni, valid_q, !(res_q.busy_res && res_q.ready_res), "busy and ready both set")
  `UET_ASSERT_SAME(a_new_idle, clk_i, rst_ni, valid_q && res_q.new_value, !res_q.busy_res, "new width while busy")
  `UET_ASSERT_NEXT(a_count_mono, clk_i, rst_ni, in_fire, res_q.error_count >= $past(res_q.error_count), "error count decreased")
  `UET_ASSERT_SAME(a_ready_empty, clk_i, rst_ni, !valid_q, s_axis_tready, "input held off with empty output")

endmodule

FILE: hdl/uet_cfg.sv
module uet_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uet_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output uet_pkg::cfg_t              cfg_o
);
  import uet_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TIMEOUT:   cfg_d.timeout_us       = pwdata[15:0];
        REG_HOLDOFF:   cfg_d.holdoff_us       = pwdata[15:0];
        REG_TRIG_W:    cfg_d.trigger_width_us = pwdata[7:0];
        REG_RISE_MIN:  cfg_d.rise_min_us      = pwdata[15:0];
        REG_RISE_MAX:  cfg_d.rise_max_us      = pwdata[15:0];
        REG_WIDTH_MIN: cfg_d.width_min_us     = pwdata[15:0];
        REG_WIDTH_MAX: cfg_d.width_max_us     = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT:   prdata = 32'(cfg_q.timeout_us);
      REG_HOLDOFF:   prdata = 32'(cfg_q.holdoff_us);
      REG_TRIG_W:    prdata = 32'(cfg_q.trigger_width_us);
      REG_RISE_MIN:  prdata = 32'(cfg_q.rise_min_us);
      REG_RISE_MAX:  prdata = 32'(cfg_q.rise_max_us);
      REG_WIDTH_MIN: prdata = 32'(cfg_q.width_min_us);
      REG_WIDTH_MAX: prdata = 32'(cfg_q.width_max_us);
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us       <= 16'd30000;
      cfg_q.holdoff_us       <= 16'd200;
      cfg_q.trigger_width_us <= 8'd5;
      cfg_q.rise_min_us      <= 16'd650;
      cfg_q.rise_max_us      <= 16'd850;
      cfg_q.width_min_us     <= 16'd100;
      cfg_q.width_max_us     <= 16'd25000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/uet_core.sv
module uet_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          echo_i,
  input  logic          start_i,
  input  uet_pkg::cfg_t cfg_i,
  output uet_pkg::res_t res_o
);
  import uet_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  pulse_q, pulse_d;
  cnt_t        st_q, st_d;
  cnt_t        rise_q, rise_d;
  cnt_t        wc_q, wc_d;
  cnt_t        sd_q, sd_d;
  logic [15:0] width_q, width_d;
  logic [15:0] total_q, total_d;

  cnt_t        sd_inc, st_inc, wc_inc;
  logic [4:0]  flags;
  logic        trig, fresh;
  logic [2:0]  adds;
  logic [16:0] sum;

  assign sd_inc = sat_inc(sd_q);
  assign st_inc = sat_inc(st_q);
  assign wc_inc = sat_inc(wc_q);

  always_comb begin
    phase_d = phase_q;
    pulse_d = pulse_q;
    st_d    = st_q;
    rise_d  = rise_q;
    wc_d    = wc_q;
    width_d = width_q;
    trig    = 1'b0;
    fresh   = 1'b0;
    flags   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          if (wide_cnt(sd_inc) < wide_reg(cfg_i.holdoff_us)) begin
            flags[FLT_HOLDOFF] = 1'b1;
          end
          pulse_d = (cfg_i.trigger_width_us == 8'd0) ? 8'd0 : cfg_i.trigger_width_us - 8'd1;
          phase_d = PH_TRIGGER;
          trig    = 1'b1;
        end
      end
      PH_TRIGGER: begin
        flags[FLT_BUSY] = start_i;
        if (pulse_q != 8'd0) begin
          pulse_d = pulse_q - 8'd1;
          trig    = 1'b1;
        end else begin
          phase_d = PH_WAIT;
          st_d    = '0;
        end
      end
      PH_WAIT, PH_RECV: begin
        flags[FLT_BUSY] = start_i;
        st_d = st_inc;
        if (phase_q == PH_WAIT) begin
          if (echo_i) begin
            rise_d  = st_inc;
            wc_d    = '0;
            phase_d = PH_RECV;
          end
        end else begin
          wc_d = wc_inc;
          if (!echo_i) begin
            width_d = (wide_cnt(wc_inc) > wide_t'(16'hFFFF)) ? 16'hFFFF
                                                              : 16'(wide_cnt(wc_inc));
            fresh   = 1'b1;
            phase_d = PH_IDLE;
            if (!(wide_cnt(rise_q) > wide_reg(cfg_i.rise_min_us) &&
                  wide_cnt(rise_q) < wide_reg(cfg_i.rise_max_us))) begin
              flags[FLT_RISE] = 1'b1;
            end
            if (!(wide_cnt(wc_inc) > wide_reg(cfg_i.width_min_us) &&
                  wide_cnt(wc_inc) < wide_reg(cfg_i.width_max_us))) begin
              flags[FLT_WIDTH] = 1'b1;
            end
          end
        end
        if (phase_d != PH_IDLE &&
            (wide_cnt(st_inc) >= wide_reg(cfg_i.timeout_us) || st_inc == CNT_MAX)) begin
          flags[FLT_TIMEOUT] = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign sd_d    = fresh ? '0 : sd_inc;
  assign adds    = 3'(flags[0]) + 3'(flags[1]) + 3'(flags[2]) + 3'(flags[3]) + 3'(flags[4]);
  assign sum     = 17'(total_q) + 17'(adds);
  assign total_d = sum[16] ? 16'hFFFF : sum[15:0];

  assign res_o.trigger_out   = trig;
  assign res_o.busy_res      = (phase_d != PH_IDLE);
  assign res_o.ready_res     = (phase_d == PH_IDLE) &&
                               (wide_cnt(sd_d) > wide_reg(cfg_i.holdoff_us));
  assign res_o.echo_width_us = width_d;
  assign res_o.new_value     = fresh;
  assign res_o.fault_flags   = flags;
  assign res_o.error_count   = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pulse_q <= '0;
      st_q    <= '0;
      rise_q  <= '0;
      wc_q    <= '0;
      sd_q    <= CNT_MAX;
      width_q <= 16'd32767;
      total_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pulse_q <= pulse_d;
      st_q    <= st_d;
      rise_q  <= rise_d;
      wc_q    <= wc_d;
      sd_q    <= sd_d;
      width_q <= width_d;
      total_q <= total_d;
    end
  end

endmodule

FILE: tb/ultrasonic_echo_timer_unit_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_timer_unit_tb;
  import uet_pkg::*;

  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD   = 400;

  // Directed ticks, bit 0 echo level and bit 1 start request.
  localparam logic [1:0] DIRECTED [24] = '{
    2'b01, 2'b10, 2'b11, 2'b01, 2'b00, 2'b00, 2'b01, 2'b01,
    2'b01, 2'b00, 2'b10, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01,
    2'b01, 2'b01, 2'b01, 2'b01, 2'b00, 2'b10, 2'b00, 2'b00
  };

  class echo_tick_checker;
    cfg_t        cfg;
    phase_e      ph;
    logic [7:0]  pulse_left;
    cnt_t        since_trigger;
    cnt_t        rise_delay;
    cnt_t        width_count;
    cnt_t        since_done;
    logic [15:0] stored_width;
    logic [15:0] fault_total;
    res_t        pending_status[$];
    int          failures;

    function new();
      cfg = '{timeout_us: 16'd30000, holdoff_us: 16'd200, trigger_width_us: 8'd5,
              rise_min_us: 16'd650, rise_max_us: 16'd850, width_min_us: 16'd100,
              width_max_us: 16'd25000};
      ph            = PH_IDLE;
      pulse_left    = '0;
      since_trigger = '0;
      rise_delay    = '0;
      width_count   = '0;
      since_done    = '1;
      stored_width  = 16'd32767;
      fault_total   = '0;
      failures      = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_TIMEOUT:   cfg.timeout_us       = v;
        REG_HOLDOFF:   cfg.holdoff_us       = v;
        REG_TRIG_W:    cfg.trigger_width_us = v[7:0];
        REG_RISE_MIN:  cfg.rise_min_us      = v;
        REG_RISE_MAX:  cfg.rise_max_us      = v;
        REG_WIDTH_MIN: cfg.width_min_us     = v;
        REG_WIDTH_MAX: cfg.width_max_us     = v;
        default: ;
      endcase
    endfunction

    function void take_tick(bit echo, bit start);
      res_t       r;
      logic [4:0] flags;
      int         total;
      r     = '0;
      flags = '0;
      if (since_done != CNT_MAX) since_done++;
      if (ph == PH_IDLE) begin
        if (start) begin
          if (since_done < cfg.holdoff_us) flags[FLT_HOLDOFF] = 1'b1;
          pulse_left = (cfg.trigger_width_us == 8'd0) ? 8'd0 : cfg.trigger_width_us - 8'd1;
          ph = PH_TRIGGER;
          r.trigger_out = 1'b1;
        end
      end else begin
        if (start) flags[FLT_BUSY] = 1'b1;
        if (ph == PH_TRIGGER) begin
          if (pulse_left != 8'd0) begin
            pulse_left--;
            r.trigger_out = 1'b1;
          end else begin
            ph = PH_WAIT;
            since_trigger = '0;
          end
        end else begin
          if (since_trigger != CNT_MAX) since_trigger++;
          if (ph == PH_WAIT) begin
            if (echo) begin
              rise_delay  = since_trigger;
              width_count = '0;
              ph = PH_RECV;
            end
          end else begin
            if (width_count != CNT_MAX) width_count++;
            if (!echo) begin
              stored_width = 16'(width_count);
              r.new_value  = 1'b1;
              since_done   = '0;
              ph = PH_IDLE;
              if (!(rise_delay > cfg.rise_min_us && rise_delay < cfg.rise_max_us))
                flags[FLT_RISE] = 1'b1;
              if (!(width_count > cfg.width_min_us && width_count < cfg.width_max_us))
                flags[FLT_WIDTH] = 1'b1;
            end
          end
          if (ph != PH_IDLE &&
              (since_trigger >= cfg.timeout_us || since_trigger == CNT_MAX)) begin
            flags[FLT_TIMEOUT] = 1'b1;
            ph = PH_IDLE;
          end
        end
      end
      total = int'(fault_total) + $countones(flags);
      if (total > 65535) total = 65535;
      fault_total     = 16'(total);
      r.busy_res      = (ph != PH_IDLE);
      r.ready_res     = (ph == PH_IDLE) && (since_done > cfg.holdoff_us);
      r.echo_width_us = stored_width;
      r.fault_flags   = flags;
      r.error_count   = fault_total;
      pending_status.push_back(r);
    endfunction

    function void check_word(logic [DATA_W-1:0] word);
      res_t got;
      res_t want;
      got = res_t'(word[RES_W-1:0]);
      if (pending_status.size() == 0) begin
        flag($sformatf("unexpected output word %h", word));
        return;
      end
      want = pending_status.pop_front();
      if (got !== want)
        flag($sformatf({"mismatch exp/act: trig %b/%b busy %b/%b ready %b/%b ",
                        "width %0d/%0d new %b/%b flags %b/%b count %0d/%0d"},
                       want.trigger_out, got.trigger_out, want.busy_res, got.busy_res,
                       want.ready_res, got.ready_res, want.echo_width_us, got.echo_width_us,
                       want.new_value, got.new_value, want.fault_flags, got.fault_flags,
                       want.error_count, got.error_count));
    endfunction

    function void close_out();
      if (pending_status.size() != 0)
        flag($sformatf("%0d output words never arrived", pending_status.size()));
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  echo_tick_checker sb;
  bit               calm;
  int               items_sent;
  int               words_seen;

  always #4 clk_i = ~clk_i;

  ultrasonic_echo_timer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  task automatic write_reg(reg_idx_e idx, logic [15:0] v);
    logic [31:0] want;
    want = (idx == REG_TRIG_W) ? {24'd0, v[7:0]} : {16'd0, v};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    if (idx != REG_UNUSED) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== want)
        sb.flag($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_TIMEOUT, c.timeout_us);
    write_reg(REG_HOLDOFF, c.holdoff_us);
    write_reg(REG_TRIG_W, {8'd0, c.trigger_width_us});
    write_reg(REG_RISE_MIN, c.rise_min_us);
    write_reg(REG_RISE_MAX, c.rise_max_us);
    write_reg(REG_WIDTH_MIN, c.width_min_us);
    write_reg(REG_WIDTH_MAX, c.width_max_us);
  endtask

  task automatic send_tick(bit echo, bit start);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, start, echo};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_tick(echo, start);
    items_sent++;
  endtask

  task automatic measure_cycle(cfg_t c);
    int gap;
    int tw;
    int rise;
    int wid;
    gap  = $urandom_range(0, (c.holdoff_us > 37) ? 40 : c.holdoff_us + 3);
    tw   = (c.trigger_width_us == 8'd0) ? 1 : c.trigger_width_us;
    rise = $urandom_range(0, (c.timeout_us > 57) ? 60 : c.timeout_us + 3);
    wid  = $urandom_range(1, 40);
    repeat (gap) send_tick(1'($urandom_range(0, 1)), 1'b0);
    send_tick(1'($urandom_range(0, 1)), 1'b1);
    repeat (tw) send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    repeat (rise) send_tick(1'b0, 1'b0);
    repeat (wid) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int stall_left;
    bit held_long;
    stall_left = 0;
    held_long  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata);
        words_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_long && words_seen >= 350) begin
        held_long  = 1'b1;
        stall_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    cfg_t c;
    int   lim;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    c = '{timeout_us: 16'd10, holdoff_us: 16'd4, trigger_width_us: 8'd2,
          rise_min_us: 16'd1, rise_max_us: 16'd6, width_min_us: 16'd1,
          width_max_us: 16'd5};
    program_regs(c);
    write_reg(REG_UNUSED, 16'hBEEF);
    foreach (DIRECTED[i]) send_tick(DIRECTED[i][0], DIRECTED[i][1]);
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        c = '{timeout_us: 16'hFFFF, holdoff_us: 16'hFFFF, trigger_width_us: 8'hFF,
              rise_min_us: 16'hFFFF, rise_max_us: 16'hFFFF, width_min_us: 16'hFFFF,
              width_max_us: 16'hFFFF};
      end else if (p == 1) begin
        c = '{timeout_us: 16'd1, holdoff_us: 16'd0, trigger_width_us: 8'd1,
              rise_min_us: 16'd0, rise_max_us: 16'd0, width_min_us: 16'd0,
              width_max_us: 16'd0};
      end else begin
        c.timeout_us       = 16'($urandom_range(4, 120));
        c.holdoff_us       = 16'($urandom_range(0, 30));
        c.trigger_width_us = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 6));
        c.rise_min_us      = 16'($urandom_range(0, 20));
        c.rise_max_us      = 16'($urandom_range(0, 40));
        c.width_min_us     = 16'($urandom_range(0, 10));
        c.width_max_us     = 16'($urandom_range(0, 35));
      end
      calm = (p == NUM_PHASES - 1);
      program_regs(c);
      lim = items_sent + PHASE_ITEMS;
      while (items_sent < lim) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          measure_cycle(c);
        end
      end
    end
    drain();
    sb.close_out();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
